@@ hdl/assert_macros.svh @@
// Assertion macros for the allocator RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FFHA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by the allocator top, controller and datapath.
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES    = 65536;
    localparam int TABLE_ENTRIES = 256;

    // Field widths of the request and result items
    localparam int REQ_W  = 17;
    localparam int ADR_W  = 16;

    // Internal widths derived from the heap and table sizes
    localparam int ST_W   = $clog2(HEAP_BYTES);
    localparam int SZ_W   = $clog2(HEAP_BYTES + 1);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        TB_FREE = 1'b0,
        TB_USED = 1'b1
    } t_tbl;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR_I,
        DP_RD_FIRST,
        DP_RD_NEXT,
        DP_CO_TOP,
        DP_CO_PROC,
        DP_CO_END,
        DP_SR_CHK,
        DP_SPLIT,
        DP_RM_SETUP,
        DP_RM_RD,
        DP_RM_WR,
        DP_RM_END,
        DP_IN_SETUP,
        DP_IN_RD,
        DP_IN_CMP,
        DP_IN_PUT,
        DP_RESULT
    } t_dp_op;

    // One extent: start offset and length in bytes
    typedef struct packed {
        logic [ST_W-1:0] start;
        logic [SZ_W-1:0] size;
    } t_ext;

    localparam t_ext INIT_EXT = '{start: '0, size: SZ_W'(HEAP_BYTES)};

    typedef struct packed {
        t_dp_op  op;
        t_tbl    tbl;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_free;
        logic size_zero;
        logic free_empty;
        logic free_full;
        logic used_full;
        logic i_lt_free;
        logic i_lt_used;
        logic i_zero;
        logic j1_lt_free;
        logic j1_lt_used;
        logic fit;
        logic tail_zero;
        logic key_less;
        logic addr_match;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/ffha_req_if.sv @@
// Request channel of the allocator: valid/ready with the request payload.
// Depends on nothing.
`default_nettype none

interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [16:0] request_size;
    logic [15:0] block_address;

    modport source (output valid, command, request_size, block_address, input ready);
    modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

`default_nettype wire

@@ hdl/ffha_rsp_if.sv @@
// Result channel of the allocator: valid/ready with the result payload.
// Depends on nothing.
`default_nettype none

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_address;
    logic [1:0]  status;

    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator over a 64 KiB heap with two sorted extent tables of
// 256 entries each, kept in single-port-per-side memories. One request is in
// work at a time; a finished result waits in an output register while the
// next request is taken. An allocate first walks the free extents and
// coalesces adjacent ones, then removes or splits the first extent that
// fits and makes a sorted insert into the used table; a zero-size allocate
// answers with no walk. A free searches the used entries for the address,
// makes a sorted insert into the free table and removes the used entry.
// Each table memory gives one read per cycle and registered read data.
// No clearing pass is needed after reset.
// Depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_ctrl, ffha_dpath.
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ffha_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_command         (i_req.command),
        .i_request_size    (i_req.request_size),
        .i_block_address   (i_req.block_address),
        .o_stat            (w_stat),
        .o_granted_address (o_rsp.granted_address),
        .o_status          (o_rsp.status)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

`default_nettype wire

@@ hdl/ffha_dpath.sv @@
// Datapath of the allocator: free and used extent tables, counters and
// walk registers. Depends on ffha_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffha_dpath
    import ffha_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_command,
    input  wire logic [REQ_W-1:0]  i_request_size,
    input  wire logic [ADR_W-1:0]  i_block_address,
    output t_dp_stat               o_stat,
    output logic [ADR_W-1:0]       o_granted_address,
    output logic [1:0]             o_status
);

    // Extent tables, one write and one read port each
    t_ext m_free [TABLE_ENTRIES];
    t_ext m_used [TABLE_ENTRIES];

    logic             r_cmd;
    logic [REQ_W-1:0] r_size;
    logic [ADR_W-1:0] r_addr;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_top_idx;
    t_ext             r_top;
    logic             r_fit;
    logic [IDX_W-1:0] r_hit_idx;
    t_ext             r_hit;
    logic [CNT_W-1:0] r_free_cnt;
    logic [CNT_W-1:0] r_used_cnt;
    logic             r_f0_ok;
    logic             r_f0_hit;
    t_tbl             r_rtbl;
    t_ext             r_frd;
    t_ext             r_urd;
    logic [ADR_W-1:0] r_granted;
    t_status          r_status;

    logic             w_we;
    t_tbl             w_wtbl;
    logic [IDX_W-1:0] w_waddr;
    t_ext             w_wdata;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    t_ext             w_rd;
    t_ext             w_key;
    t_ext             w_split;
    logic [SZ_W-1:0]  w_top_end;
    logic             w_merge;
    logic             w_top_fits;
    logic [CNT_W-1:0] w_j1;
    logic [CNT_W-1:0] w_im1;
    logic [CNT_W-1:0] w_cnt_sel;
    logic             w_key_less;

    // Read data; entry 0 of the free table shows the whole heap until written
    assign w_rd = (r_rtbl == TB_FREE) ? (r_f0_hit ? INIT_EXT : r_frd) : r_urd;

    assign w_key.start = r_hit.start;
    assign w_key.size  = (i_cmd.tbl == TB_FREE) ? r_hit.size : SZ_W'(r_size);

    assign w_split.start = r_hit.start + ST_W'(r_size);
    assign w_split.size  = r_hit.size - SZ_W'(r_size);

    assign w_top_end  = SZ_W'(r_top.start) + r_top.size;
    assign w_merge    = 32'(w_top_end) == 32'(w_rd.start);
    assign w_top_fits = 32'(r_top.size) >= 32'(r_size);
    assign w_j1       = r_j + CNT_W'(1);
    assign w_im1      = r_i - CNT_W'(1);
    assign w_cnt_sel  = (i_cmd.tbl == TB_FREE) ? r_free_cnt : r_used_cnt;
    assign w_key_less = r_hit.start < w_rd.start;

    // Table port control per operation
    always_comb begin
        w_we    = 1'b0;
        w_wtbl  = i_cmd.tbl;
        w_waddr = r_i[IDX_W-1:0];
        w_wdata = w_key;
        w_re    = 1'b0;
        w_raddr = r_i[IDX_W-1:0];
        unique case (i_cmd.op)
            DP_RD_FIRST: begin
                w_re    = 1'b1;
                w_raddr = '0;
            end
            DP_RD_NEXT: begin
                w_re = 1'b1;
            end
            DP_CO_PROC: begin
                w_we    = !w_merge;
                w_wtbl  = TB_FREE;
                w_waddr = r_top_idx[IDX_W-1:0];
                w_wdata = r_top;
            end
            DP_CO_END: begin
                w_we    = 1'b1;
                w_wtbl  = TB_FREE;
                w_waddr = r_top_idx[IDX_W-1:0];
                w_wdata = r_top;
            end
            DP_SPLIT: begin
                w_we    = 1'b1;
                w_wtbl  = TB_FREE;
                w_waddr = r_hit_idx;
                w_wdata = w_split;
            end
            DP_RM_RD: begin
                w_re    = 1'b1;
                w_raddr = w_j1[IDX_W-1:0];
            end
            DP_RM_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[IDX_W-1:0];
                w_wdata = w_rd;
            end
            DP_IN_RD: begin
                w_re    = 1'b1;
                w_raddr = w_im1[IDX_W-1:0];
            end
            DP_IN_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_key_less ? w_rd : w_key;
            end
            DP_IN_PUT: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Free table memory
    always_ff @(posedge i_clk) begin
        if (w_we && w_wtbl == TB_FREE) begin
            m_free[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_frd <= m_free[w_raddr];
        end
    end

    // Used table memory
    always_ff @(posedge i_clk) begin
        if (w_we && w_wtbl == TB_USED) begin
            m_used[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_urd <= m_used[w_raddr];
        end
    end

    // Table counts and the written flag of free entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CNT_W'(1);
            r_used_cnt <= '0;
            r_f0_ok    <= 1'b0;
        end else begin
            if (w_we && w_wtbl == TB_FREE && w_waddr == '0) begin
                r_f0_ok <= 1'b1;
            end
            unique case (i_cmd.op)
                DP_CO_END: begin
                    r_free_cnt <= r_top_idx + CNT_W'(1);
                end
                DP_RM_END: begin
                    if (i_cmd.tbl == TB_FREE) r_free_cnt <= r_free_cnt - CNT_W'(1);
                    else                      r_used_cnt <= r_used_cnt - CNT_W'(1);
                end
                DP_IN_CMP, DP_IN_PUT: begin
                    if (i_cmd.op == DP_IN_PUT || !w_key_less) begin
                        if (i_cmd.tbl == TB_FREE) r_free_cnt <= r_free_cnt + CNT_W'(1);
                        else                      r_used_cnt <= r_used_cnt + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Walk registers, request and result
    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rtbl   <= i_cmd.tbl;
            r_f0_hit <= (i_cmd.tbl == TB_FREE) && (w_raddr == '0) && !r_f0_ok;
        end
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_cmd  <= i_command;
                r_size <= i_request_size;
                r_addr <= i_block_address;
            end
            DP_CLR_I: begin
                r_i <= '0;
            end
            DP_RD_FIRST: begin
                r_i   <= CNT_W'(1);
                r_fit <= 1'b0;
            end
            DP_RD_NEXT: begin
                r_i <= r_i + CNT_W'(1);
            end
            DP_CO_TOP: begin
                r_top     <= w_rd;
                r_top_idx <= '0;
            end
            DP_CO_PROC, DP_CO_END: begin
                if (i_cmd.op == DP_CO_PROC && w_merge) begin
                    r_top.size <= r_top.size + w_rd.size;
                end else begin
                    if (!r_fit && w_top_fits) begin
                        r_fit     <= 1'b1;
                        r_hit_idx <= r_top_idx[IDX_W-1:0];
                        r_hit     <= r_top;
                    end
                    r_top_idx <= r_top_idx + CNT_W'(1);
                    r_top     <= w_rd;
                end
            end
            // Keep the matching used entry and its place for the later removal
            DP_SR_CHK: begin
                if (o_stat.addr_match) begin
                    r_hit_idx <= w_im1[IDX_W-1:0];
                    r_hit     <= w_rd;
                    r_j       <= w_im1;
                end
            end
            DP_RM_SETUP: begin
                r_j <= CNT_W'(r_hit_idx);
            end
            DP_RM_WR: begin
                r_j <= w_j1;
            end
            DP_IN_SETUP: begin
                r_i <= w_cnt_sel;
            end
            DP_IN_CMP: begin
                if (w_key_less) r_i <= w_im1;
            end
            DP_RESULT: begin
                r_status  <= i_cmd.st;
                r_granted <= (i_cmd.st == ST_OK && !r_cmd) ? ADR_W'(r_hit.start) : '0;
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller
    assign o_stat.cmd_free   = r_cmd;
    assign o_stat.size_zero  = (r_size == '0);
    assign o_stat.free_empty = (r_free_cnt == '0);
    assign o_stat.free_full  = (r_free_cnt == CNT_W'(TABLE_ENTRIES));
    assign o_stat.used_full  = (r_used_cnt == CNT_W'(TABLE_ENTRIES));
    assign o_stat.i_lt_free  = (r_i < r_free_cnt);
    assign o_stat.i_lt_used  = (r_i < r_used_cnt);
    assign o_stat.i_zero     = (r_i == '0);
    assign o_stat.j1_lt_free = (w_j1 < r_free_cnt);
    assign o_stat.j1_lt_used = (w_j1 < r_used_cnt);
    assign o_stat.fit        = r_fit;
    assign o_stat.tail_zero  = 32'(r_hit.size) == 32'(r_size);
    assign o_stat.key_less   = w_key_less;
    assign o_stat.addr_match = 32'(w_rd.start) == 32'(r_addr);

    assign o_granted_address = r_granted;
    assign o_status          = r_status;

    `FFHA_NEVER(a_free_cnt_bound, r_free_cnt > CNT_W'(TABLE_ENTRIES), "free count overflow")
    `FFHA_NEVER(a_used_cnt_bound, r_used_cnt > CNT_W'(TABLE_ENTRIES), "used count overflow")
    `FFHA_ASSERT(a_rm_in_range, (i_cmd.op == DP_RM_WR) |-> (r_j < w_cnt_sel), "shift past count")

endmodule

`default_nettype wire

@@ hdl/ffha_ctrl.sv @@
// Controller of the allocator: sequences coalescing, search, table shifts
// and the result handshake. Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CO_TOP,
        S_CO_RD,
        S_CO_PROC,
        S_DECIDE,
        S_SR_RD,
        S_SR_CHK,
        S_RM,
        S_RM_WR,
        S_INS_SET,
        S_INS,
        S_INS_CMP,
        S_RESP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_st;
    t_status n_st;
    logic    r_ovalid;
    logic    w_slot_free;
    t_tbl    w_ins_tbl;
    t_tbl    w_rm_tbl;

    assign w_slot_free = !r_ovalid || i_out_ready;
    assign w_ins_tbl   = i_stat.cmd_free ? TB_FREE : TB_USED;
    assign w_rm_tbl    = i_stat.cmd_free ? TB_USED : TB_FREE;

    // Next state and datapath command
    always_comb begin
        n_state   = r_state;
        n_st      = r_st;
        o_cmd.op  = DP_NOP;
        o_cmd.tbl = TB_FREE;
        o_cmd.st  = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.cmd_free) begin
                    o_cmd.op  = DP_CLR_I;
                    o_cmd.tbl = TB_USED;
                    n_state   = S_SR_RD;
                end else if (i_stat.size_zero || i_stat.free_empty) begin
                    n_st    = ST_NOFIT;
                    n_state = S_RESP;
                end else begin
                    o_cmd.op = DP_RD_FIRST;
                    n_state  = S_CO_TOP;
                end
            end
            S_CO_TOP: begin
                o_cmd.op = DP_CO_TOP;
                n_state  = S_CO_RD;
            end
            S_CO_RD: begin
                if (i_stat.i_lt_free) begin
                    o_cmd.op = DP_RD_NEXT;
                    n_state  = S_CO_PROC;
                end else begin
                    o_cmd.op = DP_CO_END;
                    n_state  = S_DECIDE;
                end
            end
            S_CO_PROC: begin
                o_cmd.op = DP_CO_PROC;
                n_state  = S_CO_RD;
            end
            S_DECIDE: begin
                if (!i_stat.fit) begin
                    n_st    = ST_NOFIT;
                    n_state = S_RESP;
                end else if (i_stat.used_full) begin
                    n_st    = ST_FULL;
                    n_state = S_RESP;
                end else if (i_stat.tail_zero) begin
                    o_cmd.op = DP_RM_SETUP;
                    n_state  = S_RM;
                end else begin
                    o_cmd.op = DP_SPLIT;
                    n_state  = S_INS_SET;
                end
            end
            S_SR_RD: begin
                o_cmd.tbl = TB_USED;
                if (i_stat.i_lt_used) begin
                    o_cmd.op = DP_RD_NEXT;
                    n_state  = S_SR_CHK;
                end else begin
                    n_st    = ST_UNKNOWN;
                    n_state = S_RESP;
                end
            end
            S_SR_CHK: begin
                o_cmd.op  = DP_SR_CHK;
                o_cmd.tbl = TB_USED;
                if (!i_stat.addr_match) begin
                    n_state = S_SR_RD;
                end else if (i_stat.free_full) begin
                    n_st    = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    n_state = S_INS_SET;
                end
            end
            // Close the gap left by the removed entry
            S_RM: begin
                o_cmd.tbl = w_rm_tbl;
                if (i_stat.cmd_free ? i_stat.j1_lt_used : i_stat.j1_lt_free) begin
                    o_cmd.op = DP_RM_RD;
                    n_state  = S_RM_WR;
                end else begin
                    o_cmd.op = DP_RM_END;
                    if (i_stat.cmd_free) begin
                        n_st    = ST_OK;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_INS_SET;
                    end
                end
            end
            S_RM_WR: begin
                o_cmd.op  = DP_RM_WR;
                o_cmd.tbl = w_rm_tbl;
                n_state   = S_RM;
            end
            // Sorted insert, shifting larger entries up one place
            S_INS_SET: begin
                o_cmd.op  = DP_IN_SETUP;
                o_cmd.tbl = w_ins_tbl;
                n_state   = S_INS;
            end
            S_INS: begin
                o_cmd.tbl = w_ins_tbl;
                if (i_stat.i_zero) begin
                    o_cmd.op = DP_IN_PUT;
                    if (i_stat.cmd_free) begin
                        o_cmd.op = DP_IN_PUT;
                        n_state  = S_RM;
                    end else begin
                        n_st    = ST_OK;
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.op = DP_IN_RD;
                    n_state  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_cmd.op  = DP_IN_CMP;
                o_cmd.tbl = w_ins_tbl;
                if (i_stat.key_less) begin
                    n_state = S_INS;
                end else if (i_stat.cmd_free) begin
                    n_state = S_RM;
                end else begin
                    n_st    = ST_OK;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_slot_free) begin
                    o_cmd.op = DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, result code and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_st     <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            if (r_state == S_RESP && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire
